// ----- rtl/core/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, codes and helpers for the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

  // operand fields are taken as signed values of their low bits
  localparam int unsigned OPERAND_WIDTH = 32;
  localparam int unsigned OP_SHIFT      = 32 - OPERAND_WIDTH;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_INC,
    OP_DEC,
    OP_PASS,
    OP_PASS_ALT
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_OVF,
    ST_ZERO_DEN,
    ST_GCD_UNDEF
  } status_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] first_num;
    logic signed [31:0] first_den;
    logic signed [31:0] second_num;
    logic signed [31:0] second_den;
    logic               reduce_after;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result_num;
    logic signed [63:0] result_den;
    logic [1:0]         status;
  } out_item_t;

  // sign extend the low operand bits to the full field
  function automatic logic signed [31:0] sext_op(input logic [31:0] v);
    logic signed [31:0] t;
    t = $signed(v << OP_SHIFT);
    return t >>> OP_SHIFT;
  endfunction

  // magnitude of a two's complement word, most negative maps to 2^63
  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

// ----- rtl/core/rau_gcd.sv -----
// ----------------------------------------------------------------------------
// rau_gcd
// Iterative binary gcd, one shift or compare-and-subtract per cycle
// ----------------------------------------------------------------------------
module rau_gcd (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a_in,
  input  logic [63:0] b_in,
  output logic        done,
  output logic [63:0] g
);
  import rau_pkg::*;

  typedef enum logic [2:0] {G_IDLE, G_ALIGN, G_STRIP, G_LOOP, G_FIN} gstate_t;

  gstate_t     state_r;
  logic [63:0] a_r, b_r, g_r;
  logic [5:0]  k_r;

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
    end else if (start) begin
      a_r <= a_in;
      b_r <= b_in;
      k_r <= '0;
      if (a_in == 64'd0) begin
        g_r     <= b_in;
        state_r <= G_FIN;
      end else if (b_in == 64'd0) begin
        g_r     <= a_in;
        state_r <= G_FIN;
      end else begin
        state_r <= G_ALIGN;
      end
    end else begin
      case (state_r)
        G_ALIGN: begin
          // strip common factors of two
          if ((a_r[0] | b_r[0]) == 1'b0) begin
            a_r <= a_r >> 1;
            b_r <= b_r >> 1;
            k_r <= k_r + 6'd1;
          end else begin
            state_r <= G_STRIP;
          end
        end
        G_STRIP: begin
          if (!a_r[0]) begin
            a_r <= a_r >> 1;
          end else begin
            state_r <= G_LOOP;
          end
        end
        G_LOOP: begin
          if (b_r == 64'd0) begin
            g_r     <= a_r << k_r;
            state_r <= G_FIN;
          end else if (!b_r[0]) begin
            b_r <= b_r >> 1;
          end else if (a_r > b_r) begin
            a_r <= b_r;
            b_r <= a_r - b_r;
          end else begin
            b_r <= b_r - a_r;
          end
        end
        G_FIN: begin
          state_r <= G_IDLE;
        end
        default: begin
          state_r <= G_IDLE;
        end
      endcase
    end
  end

  assign done = (state_r == G_FIN);
  assign g    = g_r;

endmodule

// ----- rtl/core/rau_div.sv -----
// ----------------------------------------------------------------------------
// rau_div
// Unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rau_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  import rau_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t     state_r;
  logic [63:0] rem_r, q_r, dvs_r;
  logic [5:0]  cnt_r;
  logic [64:0] trial;
  logic        fits;

  // shift in the next dividend bit and test against the divisor
  assign trial = {rem_r, q_r[63]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else if (start) begin
      rem_r   <= '0;
      q_r     <= dividend;
      dvs_r   <= divisor;
      cnt_r   <= 6'd63;
      state_r <= D_RUN;
    end else begin
      case (state_r)
        D_RUN: begin
          rem_r <= fits ? 64'(trial - {1'b0, dvs_r}) : trial[63:0];
          q_r   <= {q_r[62:0], fits};
          if (cnt_r == 6'd0) begin
            state_r <= D_FIN;
          end else begin
            cnt_r <= cnt_r - 6'd1;
          end
        end
        D_FIN: begin
          state_r <= D_IDLE;
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

  assign done     = (state_r == D_FIN);
  assign quotient = q_r;

endmodule

// ----- rtl/core/rational_arith_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arith_unit
// Fraction add, subtract, multiply, divide, step and pass with optional gcd reduction
// ----------------------------------------------------------------------------
//   channel  | ports                         | direction
//   ---------+-------------------------------+----------
//   in       | in_valid, in_ready, in_item   | input
//   out      | out_valid, out_ready, out_item| output
//
// One item at a time. Without reduction an item takes three passes through
// the shared 32x32 multiplier, combine, check and output load. With
// reduction add the binary gcd loop (one shift or subtract a cycle) and two
// runs of the restoring divider.
// rst_n is synchronous; in_ready is high only while the sequencer is idle.
// A result held in the output register does not stop the next item entering.
module rational_arith_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rau_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output rau_pkg::out_item_t out_item
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_COMB, S_CHECK,
    S_GCD, S_DIVN, S_DIVD, S_OUT
  } state_t;

  state_t             state_r;
  op_t                op_r;
  logic signed [31:0] n1_r, d1_r, n2_r, d2_r;
  logic               red_r, ovf_r;
  logic [63:0]        p0_r, p1_r, p2_r, rn_r, rd_r, g_r;
  status_t            status_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic [63:0]        sum, n1_x, d1_x;
  logic               sum_ovf;
  logic               gcd_start, gcd_done, div_start, div_done;
  logic [63:0]        gcd_g, div_q, div_n, div_d;

  // shared multiplier operand select
  always_comb begin
    mul_a = d1_r;
    mul_b = d2_r;
    case (state_r)
      S_MUL0: begin
        mul_a = n1_r;
        mul_b = (op_r == OP_MUL) ? n2_r : d2_r;
      end
      S_MUL1: begin
        mul_a = d1_r;
        mul_b = n2_r;
      end
      default: begin
        mul_a = d1_r;
        mul_b = d2_r;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // cross product sum or difference with overflow
  always_comb begin
    if (op_r == OP_SUB) begin
      sum     = p0_r - p1_r;
      sum_ovf = (p0_r[63] ^ p1_r[63]) & (p0_r[63] ^ sum[63]);
    end else begin
      sum     = p0_r + p1_r;
      sum_ovf = ~(p0_r[63] ^ p1_r[63]) & (p0_r[63] ^ sum[63]);
    end
  end

  assign n1_x = {{32{n1_r[31]}}, n1_r};
  assign d1_x = {{32{d1_r[31]}}, d1_r};

  // reduction unit control
  assign gcd_start = (state_r == S_CHECK) && !ovf_r && red_r &&
                     !((rn_r == 64'd0) && (rd_r == 64'd0));
  assign div_start = ((state_r == S_GCD) && gcd_done) ||
                     ((state_r == S_DIVN) && div_done);
  assign div_n     = (state_r == S_GCD) ? mag64(rn_r) : mag64(rd_r);
  assign div_d     = (state_r == S_GCD) ? gcd_g : g_r;

  rau_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .a_in  (mag64(rn_r)),
    .b_in  (mag64(rd_r)),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  rau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer and registered output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= op_t'(in_item.req_type);
            n1_r    <= sext_op(in_item.first_num);
            d1_r    <= sext_op(in_item.first_den);
            n2_r    <= sext_op(in_item.second_num);
            d2_r    <= sext_op(in_item.second_den);
            red_r   <= in_item.reduce_after;
            state_r <= S_MUL0;
          end
        end
        S_MUL0: begin
          p0_r    <= mul_p;
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          p1_r    <= mul_p;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          p2_r    <= mul_p;
          state_r <= S_COMB;
        end
        S_COMB: begin
          ovf_r <= 1'b0;
          case (op_r)
            OP_ADD, OP_SUB: begin
              rn_r  <= sum;
              rd_r  <= p2_r;
              ovf_r <= sum_ovf;
            end
            OP_MUL: begin
              rn_r <= p0_r;
              rd_r <= p2_r;
            end
            OP_DIV: begin
              rn_r <= p0_r;
              rd_r <= p1_r;
            end
            OP_INC: begin
              rn_r <= n1_x + d1_x;
              rd_r <= d1_x;
            end
            OP_DEC: begin
              rn_r <= n1_x - d1_x;
              rd_r <= d1_x;
            end
            default: begin
              rn_r <= n1_x;
              rd_r <= d1_x;
            end
          endcase
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (ovf_r) begin
            status_r <= ST_OVF;
            state_r  <= S_OUT;
          end else if (red_r && (rn_r == 64'd0) && (rd_r == 64'd0)) begin
            status_r <= ST_GCD_UNDEF;
            state_r  <= S_OUT;
          end else if (red_r) begin
            state_r <= S_GCD;
          end else begin
            status_r <= (rd_r == 64'd0) ? ST_ZERO_DEN : ST_OK;
            state_r  <= S_OUT;
          end
        end
        S_GCD: begin
          if (gcd_done) begin
            g_r     <= gcd_g;
            state_r <= S_DIVN;
          end
        end
        S_DIVN: begin
          if (div_done) begin
            rn_r    <= rn_r[63] ? (64'd0 - div_q) : div_q;
            state_r <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_done) begin
            rd_r     <= rd_r[63] ? (64'd0 - div_q) : div_q;
            status_r <= (div_q == 64'd0) ? ST_ZERO_DEN : ST_OK;
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r.result_num <= rn_r;
            out_r.result_den <= rd_r;
            out_r.status     <= status_r;
            out_valid_r      <= 1'b1;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- rtl/core/rau_checker.sv -----
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks for the rational arithmetic unit, bound to the top level
// ----------------------------------------------------------------------------
module rau_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input rau_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input rau_pkg::out_item_t out_item
);
  import rau_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // busy after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting an item");

  // no result straight after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // both-zero status leaves the fraction at zero over zero
  a_undef: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_GCD_UNDEF) |->
      (out_item.result_num == 64'd0) && (out_item.result_den == 64'd0))
    else $error("gcd undefined status with nonzero fraction");

  // zero denominator status agrees with the denominator
  a_zden: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_item.status == ST_ZERO_DEN) || (out_item.status == ST_OK)) |->
      ((out_item.status == ST_ZERO_DEN) == (out_item.result_den == 64'd0)))
    else $error("zero denominator status mismatch");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (.*);
